[hdl/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared constants, types and helper functions of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam logic [7:0]  FULL8      = 8'd255;
  localparam logic [15:0] FULL16     = 16'd65025;
  // Reciprocal of 65025 scaled by 2^32, rounded down.
  localparam logic [16:0] RECIP16    = 17'd66051;
  localparam int          RECIP_SHIFT = 32;

  localparam logic [10:0] H6_SEC1 = 11'd255;
  localparam logic [10:0] H6_SEC2 = 11'd510;
  localparam logic [10:0] H6_SEC3 = 11'd765;
  localparam logic [10:0] H6_SEC4 = 11'd1020;
  localparam logic [10:0] H6_SEC5 = 11'd1275;
  localparam logic [10:0] H6_WRAP = 11'd1530;

  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    sector_t    sector;
  } pix_t;

  // Exact floor(x / 255) for x up to 65025.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = 17'(x) + 17'(x[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

endpackage

[hdl/hsv_stream_if.sv]
// ----------------------------------------------------------------------------
// HSV pixel stream interface
// Valid/ready channel carrying one hue, saturation, brightness pixel.
// ----------------------------------------------------------------------------
interface hsv_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

[hdl/rgb_stream_if.sv]
// ----------------------------------------------------------------------------
// RGB pixel stream interface
// Valid/ready channel carrying one red, green, blue pixel.
// ----------------------------------------------------------------------------
interface rgb_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[hdl/cfg_write_if.sv]
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel carrying the write data of the mode register.
// ----------------------------------------------------------------------------
interface cfg_write_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Seven-stage pipeline that turns 8-bit HSV pixels into 8-bit RGB pixels.
// ----------------------------------------------------------------------------
// The block takes pixels on in_ch and delivers converted pixels on out_ch,
// both valid/ready channels; a transaction happens on a clock edge with valid
// and ready high. cfg_ch writes the mode bit: 1 converts HSV to RGB, 0 passes
// the pixel through unchanged. Write it only while the pipeline is empty.
// The pipeline has seven register stages, the last one being the output
// register. One pixel is accepted per cycle unless out_ch stalls; the rate
// is set by the stages, each holding no more than three multiplications of
// 8x8, 8x16 or 24x17 bits.
// Synchronous reset clears every valid bit and sets the mode to pass-through.
// When the receiver holds ready low while a result waits, the whole pipeline
// freezes and in_ch.ready drops; no pixel is lost or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hsv_stream_if.sink   in_ch,
  rgb_stream_if.source out_ch,
  cfg_write_if.sink    cfg_ch
);

  logic       hsb_mode_r;
  logic [6:0] vld_r;
  logic       en;

  pix_t        st1_r, st2_r, st3_r, st4_r, st5_r, st6_r;
  pix_t        st1_nxt;
  logic [7:0]  rem1_r, rem1_nxt;
  logic [15:0] prod_a2_r, prod_b2_r, prod_c2_r;
  logic [15:0] nq3_r, nt3_r;
  logic [7:0]  p3_r, p4_r, p5_r, p6_r;
  logic [23:0] mq4_r, mt4_r, mq5_r, mt5_r;
  logic [40:0] rq_prod, rt_prod;
  logic [7:0]  qe5_r, te5_r;
  logic [23:0] resq, rest;
  logic [7:0]  q6_r, t6_r, q6_nxt, t6_nxt;
  logic [7:0]  red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;
  logic [10:0] h6;

  assign en           = ~vld_r[6] | out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsb_mode_r <= 1'b0;
      vld_r      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        hsb_mode_r <= cfg_ch.data;
      end
      if (en) begin
        vld_r <= {vld_r[5:0], in_ch.valid};
      end
    end
  end

  always_comb begin
    h6 = {1'b0, in_ch.hue, 2'b00} + {2'b00, in_ch.hue, 1'b0};
    st1_nxt.mode = hsb_mode_r;
    st1_nxt.hue  = in_ch.hue;
    st1_nxt.sat  = in_ch.saturation;
    st1_nxt.val  = in_ch.brightness;
    if (h6 >= H6_WRAP) begin
      st1_nxt.sector = SEC_R_TO_Y;
      rem1_nxt       = 8'd0;
    end else if (h6 >= H6_SEC5) begin
      st1_nxt.sector = SEC_M_TO_R;
      rem1_nxt       = 8'(h6 - H6_SEC5);
    end else if (h6 >= H6_SEC4) begin
      st1_nxt.sector = SEC_B_TO_M;
      rem1_nxt       = 8'(h6 - H6_SEC4);
    end else if (h6 >= H6_SEC3) begin
      st1_nxt.sector = SEC_C_TO_B;
      rem1_nxt       = 8'(h6 - H6_SEC3);
    end else if (h6 >= H6_SEC2) begin
      st1_nxt.sector = SEC_G_TO_C;
      rem1_nxt       = 8'(h6 - H6_SEC2);
    end else if (h6 >= H6_SEC1) begin
      st1_nxt.sector = SEC_Y_TO_G;
      rem1_nxt       = 8'(h6 - H6_SEC1);
    end else begin
      st1_nxt.sector = SEC_R_TO_Y;
      rem1_nxt       = h6[7:0];
    end
  end

  assign rq_prod = 41'(mq4_r) * 41'(RECIP16);
  assign rt_prod = 41'(mt4_r) * 41'(RECIP16);
  assign resq    = mq5_r - 24'(qe5_r) * 24'(FULL16);
  assign rest    = mt5_r - 24'(te5_r) * 24'(FULL16);
  assign q6_nxt  = qe5_r + 8'(resq >= 24'(FULL16));
  assign t6_nxt  = te5_r + 8'(rest >= 24'(FULL16));

  always_comb begin
    if (!st6_r.mode) begin
      red_nxt   = st6_r.hue;
      green_nxt = st6_r.sat;
      blue_nxt  = st6_r.val;
    end else if (st6_r.sat == 8'd0) begin
      red_nxt   = st6_r.val;
      green_nxt = st6_r.val;
      blue_nxt  = st6_r.val;
    end else begin
      case (st6_r.sector)
        SEC_R_TO_Y: begin
          red_nxt = st6_r.val; green_nxt = t6_r;      blue_nxt = p6_r;
        end
        SEC_Y_TO_G: begin
          red_nxt = q6_r;      green_nxt = st6_r.val; blue_nxt = p6_r;
        end
        SEC_G_TO_C: begin
          red_nxt = p6_r;      green_nxt = st6_r.val; blue_nxt = t6_r;
        end
        SEC_C_TO_B: begin
          red_nxt = p6_r;      green_nxt = q6_r;      blue_nxt = st6_r.val;
        end
        SEC_B_TO_M: begin
          red_nxt = t6_r;      green_nxt = p6_r;      blue_nxt = st6_r.val;
        end
        default: begin
          red_nxt = st6_r.val; green_nxt = p6_r;      blue_nxt = q6_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r     <= st1_nxt;
      rem1_r    <= rem1_nxt;

      st2_r     <= st1_r;
      prod_a2_r <= st1_r.sat * rem1_r;
      prod_b2_r <= st1_r.sat * (FULL8 - rem1_r);
      prod_c2_r <= st1_r.val * (FULL8 - st1_r.sat);

      st3_r     <= st2_r;
      nq3_r     <= FULL16 - prod_a2_r;
      nt3_r     <= FULL16 - prod_b2_r;
      p3_r      <= div255(prod_c2_r);

      st4_r     <= st3_r;
      p4_r      <= p3_r;
      mq4_r     <= 24'(st3_r.val) * 24'(nq3_r);
      mt4_r     <= 24'(st3_r.val) * 24'(nt3_r);

      st5_r     <= st4_r;
      p5_r      <= p4_r;
      mq5_r     <= mq4_r;
      mt5_r     <= mt4_r;
      qe5_r     <= rq_prod[RECIP_SHIFT+7:RECIP_SHIFT];
      te5_r     <= rt_prod[RECIP_SHIFT+7:RECIP_SHIFT];

      st6_r     <= st5_r;
      p6_r      <= p5_r;
      q6_r      <= q6_nxt;
      t6_r      <= t6_nxt;

      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
    end
  end

  assign out_ch.valid = vld_r[6];
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

  // A waiting result that is not taken must hold off new transactions.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[6] && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // A pixel in the last compute stage reaches the output register next cycle.
  a_stage6_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[5] && en) |=> out_ch.valid)
    else $error("pixel dropped between stage six and output");

  // Before the reciprocal correction the remainder is below twice the divisor.
  a_q_corrected: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && st5_r.mode) |-> (resq < 24'(2) * 24'(FULL16)))
    else $error("reciprocal estimate of q off by more than one");

  // Zero saturation in conversion mode yields a grey pixel.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[5] && en && st6_r.mode && st6_r.sat == 8'd0)
      |=> (out_ch.red == out_ch.green && out_ch.green == out_ch.blue))
    else $error("zero saturation did not produce grey");

endmodule

[tb/sv/tb_hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives pixels through the converter in both modes. A checker class predicts
// every converted or passed-through pixel with exact integer arithmetic and
// compares it in order with the pixels that come out. Both channels idle and
// stall at random, and the mode bit is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter
  import hsv_pkg::*;
();

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  class rgb_checker;
    bit         hsb_mode;
    int         errors;
    rgb_pixel_t expected_rgb[$];

    function rgb_pixel_t hsv_to_rgb(logic [7:0] h, logic [7:0] s, logic [7:0] v);
      int unsigned h6;
      int unsigned rem;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      sector_t     sec;
      rgb_pixel_t  px;
      if (!hsb_mode) begin
        px = '{h, s, v};
      end else if (s == 8'd0) begin
        px = '{v, v, v};
      end else begin
        h6 = 32'(h) * 6;
        if (h6 >= 32'(H6_WRAP)) begin
          sec = SEC_R_TO_Y;
          rem = 0;
        end else begin
          sec = sector_t'(h6 / 255);
          rem = h6 % 255;
        end
        p = 32'(v) * (255 - 32'(s)) / 255;
        q = 32'(v) * (65025 - 32'(s) * rem) / 65025;
        t = 32'(v) * (65025 - 32'(s) * (255 - rem)) / 65025;
        case (sec)
          SEC_R_TO_Y: px = '{v, t[7:0], p[7:0]};
          SEC_Y_TO_G: px = '{q[7:0], v, p[7:0]};
          SEC_G_TO_C: px = '{p[7:0], v, t[7:0]};
          SEC_C_TO_B: px = '{p[7:0], q[7:0], v};
          SEC_B_TO_M: px = '{t[7:0], p[7:0], v};
          default:    px = '{v, p[7:0], q[7:0]};
        endcase
      end
      return px;
    endfunction

    function void note_hsv(logic [7:0] h, logic [7:0] s, logic [7:0] v);
      expected_rgb.push_back(hsv_to_rgb(h, s, v));
    endfunction

    function void check_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_pixel_t want;
      if (expected_rgb.size() == 0) begin
        $error("unexpected pixel: red %0d green %0d blue %0d", r, g, b);
        errors++;
        return;
      end
      want = expected_rgb.pop_front();
      if (r !== want.red) begin
        $error("red mismatch: expected %0d, actual %0d", want.red, r);
        errors++;
      end
      if (g !== want.green) begin
        $error("green mismatch: expected %0d, actual %0d", want.green, g);
        errors++;
      end
      if (b !== want.blue) begin
        $error("blue mismatch: expected %0d, actual %0d", want.blue, b);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  bit   long_hold;

  rgb_checker rgb_chk;

  hsv_stream_if in_if();
  rgb_stream_if out_if();
  cfg_write_if  cfg_if();

  hsv_to_rgb_converter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.hue        <= h;
    in_if.saturation <= s;
    in_if.brightness <= v;
    do @(posedge clk); while (!in_if.ready);
    rgb_chk.note_hsv(in_if.hue, in_if.saturation, in_if.brightness);
  endtask

  task automatic idle_input(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (rgb_chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    rgb_chk.hsb_mode = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_pixel(rand_byte(), rand_byte(), rand_byte());
      if (!steady) idle_input(pick_gap());
    end
  endtask

  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_if.ready <= 1'b0;
        repeat (99) @(negedge clk);
      end else begin
        n = steady ? 0 : pick_gap();
        if (n == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      rgb_chk.check_rgb(out_if.red, out_if.green, out_if.blue);
    end
  end

  initial begin
    #2000000;
    $display("hsv_to_rgb_converter regression: fail");
    $finish;
  end

  initial begin
    logic [23:0] pass_px [3];
    logic [23:0] hsv_px  [17];
    pass_px = '{24'h000000, 24'hFFFFFF, 24'hAA55AA};
    hsv_px = '{
      {8'd0,   8'd255, 8'd255}, {8'd255, 8'd255, 8'd255}, {8'd255, 8'd128, 8'd200},
      {8'd42,  8'd255, 8'd255}, {8'd43,  8'd255, 8'd255}, {8'd85,  8'd200, 8'd255},
      {8'd86,  8'd200, 8'd255}, {8'd127, 8'd255, 8'd128}, {8'd128, 8'd255, 8'd128},
      {8'd170, 8'd180, 8'd250}, {8'd171, 8'd180, 8'd250}, {8'd212, 8'd255, 8'd255},
      {8'd213, 8'd255, 8'd255}, {8'd254, 8'd255, 8'd255}, {8'd100, 8'd0,   8'd200},
      {8'd50,  8'd128, 8'd0},   {8'd30,  8'd1,   8'd255}
    };
    rgb_chk          = new();
    steady           = 1'b0;
    long_hold        = 1'b0;
    in_if.valid      = 1'b0;
    in_if.hue        = 8'd0;
    in_if.saturation = 8'd0;
    in_if.brightness = 8'd0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = 1'b0;
    rst_n            = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (pass_px[i]) begin
      send_pixel(pass_px[i][23:16], pass_px[i][15:8], pass_px[i][7:0]);
      idle_input(pick_gap());
    end
    drain();
    write_mode(1'b1);
    foreach (hsv_px[i]) begin
      send_pixel(hsv_px[i][23:16], hsv_px[i][15:8], hsv_px[i][7:0]);
      idle_input(pick_gap());
    end
    drain();

    write_mode(1'b0);
    random_phase(150);
    drain();
    write_mode(1'b1);
    random_phase(400);

    // The receiver holds off while pixels keep coming back to back.
    steady    = 1'b0;
    long_hold = 1'b1;
    repeat (80) send_pixel(rand_byte(), rand_byte(), rand_byte());
    drain();
    random_phase(400);
    drain();
    write_mode(1'b0);
    random_phase(100);
    drain();

    if (rgb_chk.errors == 0 && rgb_chk.pending() == 0) begin
      $display("hsv_to_rgb_converter regression: pass");
    end else begin
      $display("hsv_to_rgb_converter regression: fail");
    end
    $finish;
  end

endmodule
